@@ rtl/lrukv_pkg.sv @@
`timescale 1ns / 1ps
package lrukv_pkg;

  // Default sizes of the entry store.
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_KEY_BITS    = 16;
  localparam int DEF_VALUE_BITS  = 32;

  // Capacity register and occupancy field widths are fixed by the interface.
  localparam int CAP_BITS = 5;
  localparam int OCC_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Operation codes carried on the kind field.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

endpackage

@@ rtl/lrukv_in_stage.sv @@
`timescale 1ns / 1ps
module lrukv_in_stage import lrukv_pkg::*; #(
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  go,
  output logic                  stage_valid,
  output logic                  stage_kind,
  output logic [KEY_BITS-1:0]   stage_key,
  output logic [VALUE_BITS-1:0] stage_value
);

  logic take;

  // The held item leaves when the store processes it, so a new one may enter
  // in the same cycle.
  assign in_ready = !stage_valid || go;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_kind  <= kind;
      stage_key   <= key;
      stage_value <= value;
    end
  end

endmodule

@@ rtl/lrukv_store.sv @@
`timescale 1ns / 1ps
module lrukv_store import lrukv_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CAP_BITS-1:0]   cfg_data,
  input  logic                  go,
  input  logic                  op_kind,
  input  logic [KEY_BITS-1:0]   op_key,
  input  logic [VALUE_BITS-1:0] op_value,
  output logic                  res_hit,
  output logic [VALUE_BITS-1:0] res_value,
  output logic [OCC_BITS-1:0]   res_occupancy
);

  localparam int RW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam int OCW   = (CMP_W > OCC_BITS) ? CMP_W : OCC_BITS;

  logic [CAP_BITS-1:0]   capacity;
  logic [MAX_ENTRIES-1:0] valid;
  logic [KEY_BITS-1:0]   entry_key [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] entry_value [MAX_ENTRIES];
  logic [RW-1:0]         rank [MAX_ENTRIES];
  logic [CNT_W-1:0]      count;

  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] lru;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [MAX_ENTRIES-1:0] slot_oh;
  logic                   found;
  logic                   is_put;
  logic [RW-1:0]          hit_rank;
  logic [VALUE_BITS-1:0]  hit_value;
  logic [RW-1:0]          lru_rank;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;
  logic                   evict;
  logic                   do_insert;
  logic [MAX_ENTRIES-1:0] valid_next;
  logic [CNT_W-1:0]       count_next;
  logic [RW-1:0]          rank_next [MAX_ENTRIES];

  // Capacity zero acts as one; values past the store size saturate.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full     = CMP_W'(count) >= eff_cap;
  assign is_put   = (op_kind == KIND_PUT);
  assign lru_rank = RW'(count - CNT_W'(1));
  assign free_oh  = ~valid & (valid + MAX_ENTRIES'(1));

  // Every entry compares its own key; valid ranks form a permutation of
  // 0..count-1, so the oldest entry is the one ranked count-1.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid[i] && (entry_key[i] == op_key);
      lru[i]   = valid[i] && (rank[i] == lru_rank);
      if (match[i]) begin
        hit_rank  = hit_rank | rank[i];
        hit_value = hit_value | entry_value[i];
      end
    end
  end

  assign found     = |match;
  assign evict     = full && (|lru);
  assign slot_oh   = evict ? lru : free_oh;
  assign do_insert = is_put && !found && (|slot_oh);

  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_next[i] = rank[i];
    end
    if (found) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match[i]) begin
          rank_next[i] = '0;
        end else if (valid[i] && (rank[i] < hit_rank)) begin
          rank_next[i] = rank[i] + RW'(1);
        end
      end
    end else if (do_insert) begin
      valid_next = valid | slot_oh;
      if (!evict) begin
        count_next = count + CNT_W'(1);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_oh[i]) begin
          rank_next[i] = '0;
        end else if (valid[i]) begin
          rank_next[i] = rank[i] + RW'(1);
        end
      end
    end
  end

  assign res_hit       = found;
  assign res_value     = (found && !is_put) ? hit_value : '0;
  assign res_occupancy = OCC_BITS'(OCW'(count_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      valid    <= '0;
      count    <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cfg_we) begin
      capacity <= cfg_data;
      valid    <= '0;
      count    <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (go) begin
      valid <= valid_next;
      count <= count_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_put) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match[i]) begin
          entry_value[i] <= op_value;
        end else if (do_insert && slot_oh[i]) begin
          entry_key[i]   <= op_key;
          entry_value[i] <= op_value;
        end
      end
    end
  end

endmodule

@@ rtl/lrukv_out_stage.sv @@
`timescale 1ns / 1ps
module lrukv_out_stage import lrukv_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  output logic                  can_load,
  input  logic                  res_hit,
  input  logic [VALUE_BITS-1:0] res_value,
  input  logic [OCC_BITS-1:0]   res_occupancy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] read_value,
  output logic [OCC_BITS-1:0]   occupancy
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit        <= res_hit;
      read_value <= res_value;
      occupancy  <= res_occupancy;
    end
  end

endmodule

@@ rtl/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement.
// Input channel (in_valid/in_ready) carries one item: kind (get or put), key
// and value. Each item yields exactly one result item on the output channel
// (out_valid/out_ready): hit, read_value (the stored value on a get hit, else
// zero) and occupancy after the operation.
// An item accepted at a rising edge waits in the input register until the
// result register is free or being emptied; then the key compare across
// all entries, the recency update and the replacement choice run in one
// combinational pass into the result register, from which the result item
// is offered. One item per cycle is sustained as long as the receiver keeps
// out_ready high.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
// capacity register and empties the cache; it is ready whenever no item
// waits in the input register.
// Reset empties the cache and sets the capacity to sixteen. When the receiver
// stalls, the result register holds its item, the input register fills, and
// in_ready drops until the result is taken.
module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] read_value,
  output logic [OCC_BITS-1:0]   occupancy
);

  logic                  stage_valid;
  logic                  stage_kind;
  logic [KEY_BITS-1:0]   stage_key;
  logic [VALUE_BITS-1:0] stage_value;
  logic                  can_load;
  logic                  go;
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_value;
  logic [OCC_BITS-1:0]   res_occupancy;

  // An item is processed when it sits in the input register and the result
  // register is free or being emptied in the same cycle.
  assign go        = stage_valid && can_load;
  assign cfg_ready = !stage_valid;

  lrukv_in_stage #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .key         (key),
    .value       (value),
    .go          (go),
    .stage_valid (stage_valid),
    .stage_kind  (stage_kind),
    .stage_key   (stage_key),
    .stage_value (stage_value)
  );

  lrukv_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .go            (go),
    .op_kind       (stage_kind),
    .op_key        (stage_key),
    .op_value      (stage_value),
    .res_hit       (res_hit),
    .res_value     (res_value),
    .res_occupancy (res_occupancy)
  );

  lrukv_out_stage #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (go),
    .can_load      (can_load),
    .res_hit       (res_hit),
    .res_value     (res_value),
    .res_occupancy (res_occupancy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .read_value    (read_value),
    .occupancy     (occupancy)
  );

endmodule
